// ===== rtl/core/ivs_pkg.sv =====
// ----------------------------------------------------------------------------
// ivs_pkg: shared definitions for the indexed vector store
// Operation and status codes, port field widths, parameter defaults and the
// result word that passes from the sequencer to the output register.
// ----------------------------------------------------------------------------
package ivs_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_APPEND = 2'd0;
    localparam t_action ACT_GET    = 2'd1;
    localparam t_action ACT_SET    = 2'd2;
    localparam t_action ACT_REMOVE = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [DATA_W-1:0]   data;
        t_status             status;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

// ===== rtl/core/ivs_mem.sv =====
// ----------------------------------------------------------------------------
// ivs_mem: element memory
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module ivs_mem #(
    parameter int DEPTH = ivs_pkg::CAPACITY_DEF,
    parameter int WIDTH = ivs_pkg::DATA_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ivs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ivs_ctrl: operation sequencer
// Holds the live count, decodes each operation, drives the memory ports and
// walks the shift-down loop of a remove one word per cycle.
// ----------------------------------------------------------------------------
module ivs_ctrl #(
    parameter int CAPACITY   = ivs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ivs_pkg::DATA_WIDTH_DEF,
    parameter int AW         = $clog2(CAPACITY),
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ivs_pkg::t_action            i_action,
    input  logic [ivs_pkg::INDEX_W-1:0] i_index,
    input  logic [ivs_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_out_free,
    output ivs_pkg::t_result            o_result,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [DATA_WIDTH-1:0]       o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [DATA_WIDTH-1:0]       i_mem_rdata
);

    localparam int XW = (CW > ivs_pkg::INDEX_W) ? CW : ivs_pkg::INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    ivs_pkg::t_action      r_act, n_act;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    ivs_pkg::t_status      r_status, n_status;

    logic w_full;
    logic w_in_range;

    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_in_range = (XW'(i_index) < XW'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_idx    <= n_idx;
        r_ptr    <= n_ptr;
        r_word   <= n_word;
        r_data   <= n_data;
        r_status <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_act       = r_act;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_word      = r_word;
        n_data      = r_data;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = r_word;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        o_result.valid  = 1'b0;
        o_result.data   = ivs_pkg::DATA_W'(r_data);
        o_result.status = r_status;
        o_result.count  = ivs_pkg::COUNT_W'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act  = i_action;
                    n_idx  = AW'(i_index);
                    n_word = DATA_WIDTH'(i_value);
                    n_data = '0;
                    if (i_action == ivs_pkg::ACT_APPEND) begin
                        if (w_full) begin
                            n_status = ivs_pkg::ST_FULL;
                        end else begin
                            n_status    = ivs_pkg::ST_OK;
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_count);
                            o_mem_wdata = DATA_WIDTH'(i_value);
                            n_count     = r_count + CW'(1);
                        end
                        n_state = S_DONE;
                    end else if (!w_in_range) begin
                        n_status = ivs_pkg::ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_status    = ivs_pkg::ST_OK;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(i_index);
                        n_state     = S_READ;
                    end
                end
            end
            S_READ: begin
                n_data = i_mem_rdata;
                case (r_act)
                    ivs_pkg::ACT_SET: begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_idx;
                        o_mem_wdata = r_word;
                        n_state     = S_DONE;
                    end
                    ivs_pkg::ACT_REMOVE: begin
                        if ((CW'(r_idx) + CW'(1)) < r_count) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_idx + AW'(1);
                            n_ptr       = r_idx + AW'(1);
                            n_state     = S_SHIFT;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                // The word read last cycle moves down one place while the
                // next one is fetched.
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr - AW'(1);
                o_mem_wdata = i_mem_rdata;
                if ((CW'(r_ptr) + CW'(1)) < r_count) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_ptr + AW'(1);
                    n_ptr       = r_ptr + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_result.valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/core/indexed_vector_store.sv =====
// ----------------------------------------------------------------------------
// indexed_vector_store: ordered word store with append, get, set and remove
// Input words are taken only while the sequencer is idle, so each operation
// finishes and hands its result to the output register before the next one
// is accepted. The remove shift loop moves one element per cycle through
// the single read and single write port of the element memory.
// Reset: synchronous, active low; clears the live count and the sequencer.
// ----------------------------------------------------------------------------
module indexed_vector_store #(
    parameter int CAPACITY   = ivs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ivs_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ivs_pkg::ACTION_W-1:0] i_action,
    input  logic [ivs_pkg::INDEX_W-1:0]  i_index,
    input  logic [ivs_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ivs_pkg::DATA_W-1:0]   o_data,
    output logic [ivs_pkg::STATUS_W-1:0] o_status,
    output logic [ivs_pkg::COUNT_W-1:0]  o_count
);

    // Address width of the element memory and width of the live count,
    // which must be able to hold CAPACITY itself.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [DATA_WIDTH-1:0] w_mem_wdata;
    logic                  w_mem_re;
    logic [AW-1:0]         w_mem_raddr;
    logic [DATA_WIDTH-1:0] w_mem_rdata;

    ivs_pkg::t_result w_result;
    ivs_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_out_free;

    // The output register can take a new word when it is empty or when its
    // current word leaves in this cycle. The sequencer holds a finished
    // result until then, but it is free to accept the next input word as soon
    // as that result has moved into the output register.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // The sequencer owns the live count and walks each operation through the
    // memory: a registered read for indexed operations, then a write back where
    // the operation modifies the store. Reads and writes of the same entry never
    // fall in the same cycle, so no forwarding path is needed.
    ivs_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_out_free  (w_out_free),
        .o_result    (w_result),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // Element storage. Entries at or above the live count are never read,
    // so the memory needs no clearing after reset.
    ivs_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Output register: separates the sequencer from a stalling consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out.data;
    assign o_status    = r_out.status;
    assign o_count     = r_out.count;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the indexed vector store
// Drives append, get, set and remove words through the valid/stall input
// channel. A local copy of the store predicts each reply, and a checker
// compares every output word against the oldest pending prediction. Random
// phases fill the store to capacity, drain it, and vary the idle and stall
// pressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    // Expected reply for one accepted operation, in output port order.
    typedef struct packed {
        logic [ivs_pkg::DATA_W-1:0]  data;
        ivs_pkg::t_status            status;
        logic [ivs_pkg::COUNT_W-1:0] count;
    } t_store_reply;

    // Every input of the block starts at a known value.
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic [ivs_pkg::ACTION_W-1:0] i_action    = ivs_pkg::ACT_APPEND;
    logic [ivs_pkg::INDEX_W-1:0]  i_index     = '0;
    logic [ivs_pkg::VALUE_W-1:0]  i_value     = '0;
    logic                         i_out_stall = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [ivs_pkg::DATA_W-1:0]   o_data;
    logic [ivs_pkg::STATUS_W-1:0] o_status;
    logic [ivs_pkg::COUNT_W-1:0]  o_count;

    // Shadow copy of the store contents and its live count. Entries at or
    // above the count are never read, so their initial value does not matter.
    logic [ivs_pkg::DATA_W-1:0] stored_words [ivs_pkg::CAPACITY_DEF];
    int                         stored_count = 0;
    int                         highest_count = 0;

    // Predicted replies, oldest first. The block answers strictly in order.
    t_store_reply pending_replies [$];

    // Idle and stall rates, in percent, for the current phase.
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    int fail_count      = 0;
    int replies_checked = 0;
    int range_seen      = 0;
    int full_seen       = 0;
    int sent_per_action [4] = '{0, 0, 0, 0};

    indexed_vector_store #(
        .CAPACITY   (ivs_pkg::CAPACITY_DEF),
        .DATA_WIDTH (ivs_pkg::DATA_WIDTH_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the shadow store and return the reply that the
    // block must give for it. Append answers with data zero; an append to a
    // full store and any indexed access at or past the count leave the store
    // untouched and answer with data zero and an error status.
    function automatic t_store_reply apply_store_op(
        input ivs_pkg::t_action             act,
        input logic [ivs_pkg::INDEX_W-1:0]  idx,
        input logic [ivs_pkg::VALUE_W-1:0]  val
    );
        t_store_reply reply;
        int           k;
        reply.data   = '0;
        reply.status = ivs_pkg::ST_OK;
        if (act == ivs_pkg::ACT_APPEND) begin
            if (stored_count >= ivs_pkg::CAPACITY_DEF) begin
                reply.status = ivs_pkg::ST_FULL;
            end else begin
                stored_words[stored_count] = val;
                stored_count++;
            end
        end else if (int'(idx) >= stored_count) begin
            reply.status = ivs_pkg::ST_RANGE;
        end else begin
            reply.data = stored_words[idx];
            if (act == ivs_pkg::ACT_SET) begin
                stored_words[idx] = val;
            end else if (act == ivs_pkg::ACT_REMOVE) begin
                // Every later word moves down one place.
                for (k = int'(idx); k + 1 < stored_count; k++) begin
                    stored_words[k] = stored_words[k + 1];
                end
                stored_count--;
            end
        end
        if (stored_count > highest_count) begin
            highest_count = stored_count;
        end
        reply.count = stored_count[ivs_pkg::COUNT_W-1:0];
        return reply;
    endfunction

    // Offer one word on the input channel and hold it until it is taken.
    // Valid stays high on return so that back-to-back words need no extra
    // edge; the next call or the drain lowers it. Idle cycles are rolled
    // before the word is raised, never while it is waiting, so valid does not
    // depend on stall and a waiting payload never changes.
    task automatic send_word(input ivs_pkg::t_action act,
                             input logic [ivs_pkg::INDEX_W-1:0] idx,
                             input logic [ivs_pkg::VALUE_W-1:0] val);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        // Accepted at this edge: predict in acceptance order.
        pending_replies.push_back(apply_store_op(act, idx, val));
        sent_per_action[act]++;
    endtask

    // Stop sending and wait until every predicted reply has been checked.
    task automatic wait_for_replies;
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Output side: random stalls, and a check of every word taken.
    // Outputs are sampled at the edge, before the block updates them.
    always @(posedge i_clk) begin : reply_checker
        t_store_reply want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("[%0t] unexpected output word: data=%h status=%0d count=%0d",
                                 $realtime, o_data, o_status, o_count);
                    end
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (want.status == ivs_pkg::ST_RANGE) begin
                        range_seen++;
                    end
                    if (want.status == ivs_pkg::ST_FULL) begin
                        full_seen++;
                    end
                    if (o_data !== want.data || o_status !== want.status
                            || o_count !== want.count) begin
                        if (fail_count < 10) begin
                            $display({"[%0t] reply mismatch: expected data=%h",
                                      " status=%0d count=%0d, got data=%h",
                                      " status=%0d count=%0d"},
                                     $realtime, want.data, want.status, want.count,
                                     o_data, o_status, o_count);
                        end
                        fail_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Indexed accesses on an empty store must all be rejected.
    task automatic test_empty_store;
        send_word(ivs_pkg::ACT_GET, 6'd0, 32'h0000_0000);
        send_word(ivs_pkg::ACT_SET, 6'd63, 32'hFFFF_FFFF);
        send_word(ivs_pkg::ACT_REMOVE, 6'd0, 32'h1234_5678);
    endtask

    // A short hand-written sequence: extreme data values, each operation,
    // an access exactly at the count, and removes from the front and the end.
    task automatic test_basic_ops;
        send_word(ivs_pkg::ACT_APPEND, 6'd0, 32'h0000_0000);
        send_word(ivs_pkg::ACT_APPEND, 6'd63, 32'hFFFF_FFFF);
        send_word(ivs_pkg::ACT_APPEND, 6'd0, 32'h1234_5678);
        send_word(ivs_pkg::ACT_APPEND, 6'd0, 32'h8000_0001);
        send_word(ivs_pkg::ACT_GET, 6'd0, 32'h0000_0000);
        send_word(ivs_pkg::ACT_GET, 6'd3, 32'h0000_0000);
        send_word(ivs_pkg::ACT_GET, 6'd4, 32'h0000_0000);
        send_word(ivs_pkg::ACT_SET, 6'd1, 32'h5A5A_A5A5);
        send_word(ivs_pkg::ACT_SET, 6'd63, 32'hA5A5_5A5A);
        send_word(ivs_pkg::ACT_GET, 6'd1, 32'h0000_0000);
        send_word(ivs_pkg::ACT_REMOVE, 6'd0, 32'h0000_0000);
        send_word(ivs_pkg::ACT_REMOVE, 6'd2, 32'h0000_0000);
        send_word(ivs_pkg::ACT_REMOVE, 6'd2, 32'h0000_0000);
        send_word(ivs_pkg::ACT_GET, 6'd1, 32'h0000_0000);
        send_word(ivs_pkg::ACT_REMOVE, 6'd1, 32'h0000_0000);
        send_word(ivs_pkg::ACT_REMOVE, 6'd0, 32'h0000_0000);
        send_word(ivs_pkg::ACT_GET, 6'd0, 32'h0000_0000);
    endtask

    // Random mix of all four operations. Appends are favored while the store
    // is nearly empty and held back near capacity, so the count wanders over
    // its whole range. Most indices are live; the rest are any 6-bit value.
    task automatic test_random_mix(input int num_words);
        ivs_pkg::t_action             act;
        logic [ivs_pkg::INDEX_W-1:0]  idx;
        int                           append_pct;
        repeat (num_words) begin
            append_pct = (stored_count < 8) ? 60 : (stored_count > 56) ? 15 : 32;
            if ($urandom_range(99) < append_pct) begin
                act = ivs_pkg::ACT_APPEND;
            end else begin
                case ($urandom_range(2))
                    0:       act = ivs_pkg::ACT_GET;
                    1:       act = ivs_pkg::ACT_SET;
                    default: act = ivs_pkg::ACT_REMOVE;
                endcase
            end
            if (stored_count > 0 && $urandom_range(99) < 85) begin
                idx = ivs_pkg::INDEX_W'($urandom_range(stored_count - 1));
            end else begin
                idx = ivs_pkg::INDEX_W'($urandom);
            end
            send_word(act, idx, $urandom);
        end
    endtask

    // Fill the store to capacity, push a few appends into the full store,
    // touch some entries, then drain it again. Removes from the front give
    // the longest shifts; removes from the end give none.
    task automatic test_fill_and_drain;
        logic [ivs_pkg::INDEX_W-1:0] idx;
        int                          roll;
        while (stored_count < ivs_pkg::CAPACITY_DEF) begin
            send_word(ivs_pkg::ACT_APPEND, ivs_pkg::INDEX_W'($urandom), $urandom);
        end
        repeat (3) begin
            send_word(ivs_pkg::ACT_APPEND, ivs_pkg::INDEX_W'($urandom), $urandom);
        end
        send_word(ivs_pkg::ACT_GET, 6'd63, $urandom);
        repeat (6) begin
            idx = ivs_pkg::INDEX_W'($urandom);
            send_word($urandom_range(1) ? ivs_pkg::ACT_GET : ivs_pkg::ACT_SET, idx,
                      $urandom);
        end
        while (stored_count > 0) begin
            roll = $urandom_range(9);
            if (roll < 3) begin
                idx = '0;
            end else if (roll < 5) begin
                idx = ivs_pkg::INDEX_W'(stored_count - 1);
            end else begin
                idx = ivs_pkg::INDEX_W'($urandom_range(stored_count - 1));
            end
            send_word((roll == 9) ? ivs_pkg::ACT_SET : ivs_pkg::ACT_REMOVE, idx,
                      $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: no idling on either side.
        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_empty_store;
        test_basic_ops;
        test_random_mix(135);
        test_fill_and_drain;
        wait_for_replies;

        // Phase two: the sender idles about half the time.
        in_idle_pct   = 48;
        out_stall_pct = 0;
        test_random_mix(135);
        wait_for_replies;

        // Phase three: the receiver stalls about half the time.
        in_idle_pct   = 0;
        out_stall_pct = 48;
        test_random_mix(135);
        wait_for_replies;

        // Phase four: both sides hold back now and then.
        in_idle_pct   = 24;
        out_stall_pct = 24;
        test_fill_and_drain;
        test_random_mix(135);
        wait_for_replies;

        // Anything that shows up in this final window is an extra output word.
        out_stall_pct = 0;
        repeat (80) @(posedge i_clk);

        $display("Sent %0d appends, %0d gets, %0d sets, %0d removes under four idle mixes.",
                 sent_per_action[ivs_pkg::ACT_APPEND], sent_per_action[ivs_pkg::ACT_GET],
                 sent_per_action[ivs_pkg::ACT_SET], sent_per_action[ivs_pkg::ACT_REMOVE]);
        $display({"Checked %0d replies (%0d out of range, %0d store full),",
                  " peak count %0d, %0d errors."},
                 replies_checked, range_seen, full_seen, highest_count, fail_count);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop in case the block hangs; a correct run needs a small
    // fraction of this time.
    initial begin
        #10_000_000;
        $display("Timeout with %0d replies outstanding.", pending_replies.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
